// ===== hdl/bsc_pkg.sv =====
// package: shared types and constants of the barometric compensation block
package bsc_pkg;

  localparam int unsigned FieldBits = 20;
  localparam int unsigned NumW      = 76;
  localparam int unsigned DivW      = 40;

  typedef enum logic [1:0] {
    CFG_TRIM_T      = 2'd0,
    CFG_TRIM_P_LOW  = 2'd1,
    CFG_TRIM_P_MID  = 2'd2,
    CFG_TRIM_P_HIGH = 2'd3
  } bsc_cfg_e;

  typedef struct packed {
    logic        [15:0] t1;
    logic signed [15:0] t2;
    logic signed [15:0] t3;
    logic        [15:0] p1;
    logic signed [15:0] p2;
    logic signed [15:0] p3;
    logic signed [15:0] p4;
    logic signed [15:0] p5;
    logic signed [15:0] p6;
    logic signed [15:0] p7;
    logic signed [15:0] p8;
    logic signed [15:0] p9;
  } bsc_trim_t;

  // word between front and back
  typedef struct packed {
    logic signed [23:0] tc;
    logic signed [26:0] v1;
    logic        [19:0] rp;
  } bsc_mid_t;

  // sideband carried through the divider
  typedef struct packed {
    logic signed [23:0] tc;
    logic               dz;
    logic               pneg;
  } bsc_side_t;

  // result word
  typedef struct packed {
    logic signed [23:0] tc;
    logic        [31:0] pres;
    logic               dz;
  } bsc_res_t;

endpackage

// ===== hdl/bsc_fifo.sv =====
// small register queue used between front and back and at the output
module bsc_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [Width-1:0] rdata_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/bsc_front.sv =====
// front: takes raw words, computes fine temperature and centidegrees
module bsc_front
  import bsc_pkg::*;
#(
  parameter int unsigned RAW_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  output logic                 ready_o,
  input  logic [FieldBits-1:0] raw_temperature_i,
  input  logic [FieldBits-1:0] raw_pressure_i,
  input  bsc_trim_t            trim_i,
  input  logic                 mid_full_i,
  output logic                 mid_push_o,
  output bsc_mid_t             mid_word_o
);

  localparam logic [FieldBits-1:0] RawMask =
    FieldBits'(((64'd1 << RAW_BITS) - 64'd1) << (FieldBits - RAW_BITS));

  logic [6:0] vld_q;
  logic       en;

  logic [19:0]        rt_q, rp0_q, rp1_q, rp2_q, rp3_q, rp4_q, rp5_q, rp6_q;
  logic signed [19:0] a_q, a_d;
  logic signed [18:0] dd_q, dd_d;
  logic signed [35:0] ma_q, ma_d;
  logic [31:0]        dsq_q, dsq_d;
  logic signed [24:0] va_q, va_d, va4_q;
  logic [19:0]        dq_q;
  logic signed [36:0] mb_q, mb_d;
  logic signed [25:0] tf_q, tf_d;
  logic signed [23:0] tc_q, tc_d;
  logic signed [26:0] v1_q, v1_d;

  assign en         = !vld_q[6] || !mid_full_i;
  assign ready_o    = en;
  assign mid_push_o = vld_q[6] && en;
  assign mid_word_o = '{tc: tc_q, v1: v1_q, rp: rp6_q};

  always_comb begin
    logic signed [37:0] sq;
    logic signed [35:0] maw;
    logic signed [36:0] mbw;
    logic signed [29:0] t5;
    a_d   = $signed({3'b0, rt_q[19:3]}) - $signed({3'b0, trim_i.t1, 1'b0});
    dd_d  = $signed({3'b0, rt_q[19:4]}) - $signed({3'b0, trim_i.t1});
    ma_d  = a_q * trim_i.t2;
    sq    = dd_q * dd_q;
    dsq_d = sq[31:0];
    maw   = (ma_q + (ma_q[35] ? 36'sd2047 : 36'sd0)) >>> 11;
    va_d  = maw[24:0];
    mb_d  = $signed({1'b0, dq_q}) * trim_i.t3;
    mbw   = (mb_q + (mb_q[36] ? 37'sd16383 : 37'sd0)) >>> 14;
    tf_d  = 26'(va4_q) + 26'($signed(mbw[22:0]));
    t5    = 30'(tf_q) * 30'sd5 + 30'sd128;
    t5    = (t5 + (t5[29] ? 30'sd255 : 30'sd0)) >>> 8;
    tc_d  = t5[23:0];
    v1_d  = 27'(tf_q) - 27'sd128000;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[5:0], push_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rt_q  <= raw_temperature_i & RawMask;
      rp0_q <= raw_pressure_i & RawMask;
      a_q   <= a_d;
      dd_q  <= dd_d;
      rp1_q <= rp0_q;
      ma_q  <= ma_d;
      dsq_q <= dsq_d;
      rp2_q <= rp1_q;
      va_q  <= va_d;
      dq_q  <= dsq_q[31:12];
      rp3_q <= rp2_q;
      va4_q <= va_q;
      mb_q  <= mb_d;
      rp4_q <= rp3_q;
      tf_q  <= tf_d;
      rp5_q <= rp4_q;
      tc_q  <= tc_d;
      v1_q  <= v1_d;
      rp6_q <= rp5_q;
    end
  end

endmodule

// ===== hdl/bsc_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module bsc_div
  import bsc_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DivW-1:0] den_i,
  input  bsc_side_t       side_i,
  output logic            valid_o,
  output logic [NumW-1:0] quot_o,
  output bsc_side_t       side_o
);

  logic [NumW-1:0] num_q [NumW];
  logic [DivW-1:0] rem_q [NumW];
  logic [DivW-1:0] den_q [NumW];
  bsc_side_t       side_q [NumW];
  logic [NumW-1:0] vld_q;

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [NumW-1:0] num_in;
    logic [DivW-1:0] rem_in, den_in;
    bsc_side_t       side_in;
    logic            vin, ge;
    logic [DivW:0]   trial, diff;

    if (k == 0) begin : g_first
      assign num_in  = num_i;
      assign rem_in  = '0;
      assign den_in  = den_i;
      assign side_in = side_i;
      assign vin     = valid_i;
    end else begin : g_next
      assign num_in  = num_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign den_in  = den_q[k-1];
      assign side_in = side_q[k-1];
      assign vin     = vld_q[k-1];
    end

    assign trial = {rem_in, num_in[NumW-1]};
    assign ge    = trial >= {1'b0, den_in};
    assign diff  = trial - {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[k]  <= {num_in[NumW-2:0], ge};
        rem_q[k]  <= ge ? diff[DivW-1:0] : trial[DivW-1:0];
        den_q[k]  <= den_in;
        side_q[k] <= side_in;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vin;
      end
    end
  end

  assign valid_o = vld_q[NumW-1];
  assign quot_o  = num_q[NumW-1];
  assign side_o  = side_q[NumW-1];

endmodule

// ===== hdl/bsc_back.sv =====
// back: pressure polynomial, division and output saturation
module bsc_back
  import bsc_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bsc_trim_t trim_i,
  input  logic      mid_empty_i,
  input  bsc_mid_t  mid_word_i,
  output logic      mid_pop_o,
  input  logic      out_full_i,
  output logic      out_push_o,
  output bsc_res_t  out_word_o
);

  logic       en;
  logic [5:0] bv_q;
  logic [7:0] av_q;

  logic signed [23:0] tc1_q, tc2_q, tc3_q, tc4_q, tc5_q, tc6_q;
  logic [19:0]        rp1_q, rp2_q, rp3_q;
  logic signed [53:0] v1sq_q;
  logic signed [42:0] v1p5_q, v1p2_q, v1p5b_q, v1p2b_q;
  logic signed [69:0] sqp6_q, sqp3_q;
  logic signed [71:0] v2_q, v2_d, big_q, big_d, x_q, x_d;
  logic [55:0]        mbig_q, mbig_d;
  logic               dneg4_q, dneg5_q;
  logic [63:0]        magx_q, magx_d;
  logic [43:0]        bplo_q, bphi_q;
  logic [DivW-1:0]    dmag_q, dmag_d;
  logic [NumW-1:0]    n_q;
  logic               xneg_q, pneg6_q;

  logic            dv;
  logic [NumW-1:0] quot;
  bsc_side_t       dside;

  bsc_side_t    s7_q, s8_q, s9_q, s10_q, s11_q, s12_q, s13_q, s14_q;
  logic [60:0]  pm7_q, pm8_q, pm9_q, pm10_q, pm11_q;
  logic [46:0]  pmlo_q;
  logic [45:0]  pmhi_q;
  logic [47:0]  ll_q, lh_q, hh_q;
  logic [58:0]  t2m_q, t2m_d, t2m10_q, t2m11_q;
  logic [96:0]  sq_q, sq_d;
  logic [63:0]  mlo_q;
  logic [64:0]  mhi_q;
  logic [88:0]  t1m_q, t1m_d;
  logic [93:0]  s_q, s_d, sh_q, sh_d;
  logic [31:0]  pres_q, pres_d;
  logic [15:0]  magp8, magp9;
  logic [47:0]  magq;

  assign en         = !av_q[7] || !out_full_i;
  assign mid_pop_o  = !mid_empty_i && en;
  assign out_push_o = av_q[7] && en;
  assign out_word_o = '{tc: s14_q.tc, pres: pres_q, dz: s14_q.dz};

  assign magp8 = trim_i.p8[15] ? (16'd0 - trim_i.p8) : trim_i.p8;
  assign magp9 = trim_i.p9[15] ? (16'd0 - trim_i.p9) : trim_i.p9;
  assign magq  = pm7_q[60:13];

  always_comb begin
    logic signed [69:0] sq3;
    logic [20:0]        rd;
    logic signed [71:0] babs, xabs;
    logic [72:0]        dsum;
    logic [77:0]        tsum;
    logic [113:0]       msum;
    logic [93:0]        tp, t1, t2, sabs, shv, r;
    sq3    = (sqp3_q + (sqp3_q[69] ? 70'sd255 : 70'sd0)) >>> 8;
    v2_d   = 72'(sqp6_q) + (72'(v1p5b_q) <<< 17) + (72'(trim_i.p4) <<< 35);
    big_d  = 72'sh800000000000 + 72'(sq3) + (72'(v1p2b_q) <<< 12);
    rd     = 21'h100000 - {1'b0, rp3_q};
    x_d    = $signed({20'b0, rd, 31'b0}) - v2_q;
    babs   = big_q[71] ? -big_q : big_q;
    mbig_d = babs[55:0];
    xabs   = x_q[71] ? -x_q : x_q;
    magx_d = xabs[63:0];
    dsum   = {1'b0, bphi_q, 28'b0} + 73'(bplo_q);
    dmag_d = dsum[72:33];
    tsum   = {1'b0, pmhi_q, 31'b0} + 78'(pmlo_q);
    t2m_d  = tsum[77:19];
    sq_d   = {1'b0, hh_q, 48'b0} + 97'({lh_q, 25'b0}) + 97'(ll_q);
    msum   = {1'b0, mhi_q, 48'b0} + 114'(mlo_q);
    t1m_d  = msum[113:25];
    tp     = s11_q.pneg ? (94'd0 - 94'(pm11_q)) : 94'(pm11_q);
    t1     = trim_i.p9[15] ? (94'd0 - 94'(t1m_q)) : 94'(t1m_q);
    t2     = (trim_i.p8[15] ^ s11_q.pneg) ? (94'd0 - 94'(t2m11_q)) : 94'(t2m11_q);
    s_d    = tp + t1 + t2;
    sabs   = s_q[93] ? (94'd0 - s_q) : s_q;
    shv    = sabs >> 8;
    sh_d   = s_q[93] ? (94'd0 - shv) : shv;
    r      = sh_q + {{74{trim_i.p7[15]}}, trim_i.p7, 4'b0};
    if (s13_q.dz || r[93]) begin
      pres_d = '0;
    end else if (|r[93:32]) begin
      pres_d = 32'hFFFF_FFFF;
    end else begin
      pres_d = r[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bv_q <= '0;
      av_q <= '0;
    end else if (en) begin
      bv_q <= {bv_q[4:0], mid_pop_o};
      av_q <= {av_q[6:0], dv};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      // polynomial terms
      tc1_q   <= mid_word_i.tc;
      rp1_q   <= mid_word_i.rp;
      v1sq_q  <= mid_word_i.v1 * mid_word_i.v1;
      v1p5_q  <= mid_word_i.v1 * trim_i.p5;
      v1p2_q  <= mid_word_i.v1 * trim_i.p2;
      tc2_q   <= tc1_q;
      rp2_q   <= rp1_q;
      sqp6_q  <= v1sq_q * trim_i.p6;
      sqp3_q  <= v1sq_q * trim_i.p3;
      v1p5b_q <= v1p5_q;
      v1p2b_q <= v1p2_q;
      tc3_q   <= tc2_q;
      rp3_q   <= rp2_q;
      v2_q    <= v2_d;
      big_q   <= big_d;
      tc4_q   <= tc3_q;
      x_q     <= x_d;
      mbig_q  <= mbig_d;
      dneg4_q <= big_q[71];
      tc5_q   <= tc4_q;
      magx_q  <= magx_d;
      xneg_q  <= x_q[71];
      dneg5_q <= dneg4_q;
      bplo_q  <= mbig_q[27:0] * trim_i.p1;
      bphi_q  <= mbig_q[55:28] * trim_i.p1;
      tc6_q   <= tc5_q;
      dmag_q  <= dmag_d;
      n_q     <= NumW'(magx_q) * NumW'(3125);
      pneg6_q <= xneg_q ^ dneg5_q;
      // after the divider
      s7_q    <= dside;
      pm7_q   <= (quot > NumW'(76'h1000000000000000)) ? 61'h1000000000000000 : quot[60:0];
      s8_q    <= s7_q;
      pm8_q   <= pm7_q;
      pmlo_q  <= pm7_q[30:0] * magp8;
      pmhi_q  <= pm7_q[60:31] * magp8;
      ll_q    <= magq[23:0] * magq[23:0];
      lh_q    <= magq[23:0] * magq[47:24];
      hh_q    <= magq[47:24] * magq[47:24];
      s9_q    <= s8_q;
      pm9_q   <= pm8_q;
      t2m_q   <= t2m_d;
      sq_q    <= sq_d;
      s10_q   <= s9_q;
      pm10_q  <= pm9_q;
      t2m10_q <= t2m_q;
      mlo_q   <= sq_q[47:0] * magp9;
      mhi_q   <= sq_q[96:48] * magp9;
      s11_q   <= s10_q;
      pm11_q  <= pm10_q;
      t2m11_q <= t2m10_q;
      t1m_q   <= t1m_d;
      s12_q   <= s11_q;
      s_q     <= s_d;
      s13_q   <= s12_q;
      sh_q    <= sh_d;
      s14_q   <= s13_q;
      pres_q  <= pres_d;
    end
  end

  bsc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (bv_q[5]),
    .num_i   (n_q),
    .den_i   (dmag_q),
    .side_i  ('{tc: tc6_q, dz: (dmag_q == '0), pneg: pneg6_q}),
    .valid_o (dv),
    .quot_o  (quot),
    .side_o  (dside)
  );

endmodule

// ===== hdl/barometric_sensor_compensation.sv =====
// top level: trim registers, front and back with queues between and after
// throughput: one word per cycle while the outputs are not stalled, set by the fully pipelined 76-stage divider
// full rises when the middle queue is full and the last front stage holds a word
// reset: asynchronous, active low; clears all trims to zero and empties the pipeline
module barometric_sensor_compensation
  import bsc_pkg::*;
#(
  parameter int unsigned RAW_BITS = 20
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [FieldBits-1:0] raw_temperature_i,
  input  logic [FieldBits-1:0] raw_pressure_i,
  input  logic                 pop,
  output logic                 empty,
  output logic signed [23:0]   temperature_centi_o,
  output logic [31:0]          pressure_q24_8_o,
  output logic                 divisor_zero_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [63:0]          cfg_data_i
);

  logic [47:0] trim_t_q;
  logic [63:0] trim_pl_q, trim_pm_q;
  logic [15:0] trim_ph_q;
  bsc_trim_t   trim;

  logic     ready, mid_push, mid_full, mid_pop, mid_empty, out_push, out_full;
  bsc_mid_t mid_in, mid_out;
  bsc_res_t res_in, res_out;

  assign cfg_ready_o = 1'b1;
  assign full        = !ready;

  assign trim = '{
    t1: trim_t_q[15:0],   t2: trim_t_q[31:16],  t3: trim_t_q[47:32],
    p1: trim_pl_q[15:0],  p2: trim_pl_q[31:16], p3: trim_pl_q[47:32], p4: trim_pl_q[63:48],
    p5: trim_pm_q[15:0],  p6: trim_pm_q[31:16], p7: trim_pm_q[47:32], p8: trim_pm_q[63:48],
    p9: trim_ph_q
  };

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trim_t_q  <= '0;
      trim_pl_q <= '0;
      trim_pm_q <= '0;
      trim_ph_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (bsc_cfg_e'(cfg_index_i))
        CFG_TRIM_T:      trim_t_q  <= cfg_data_i[47:0];
        CFG_TRIM_P_LOW:  trim_pl_q <= cfg_data_i;
        CFG_TRIM_P_MID:  trim_pm_q <= cfg_data_i;
        CFG_TRIM_P_HIGH: trim_ph_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  bsc_front #(
    .RAW_BITS (RAW_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push_i            (push),
    .ready_o           (ready),
    .raw_temperature_i (raw_temperature_i),
    .raw_pressure_i    (raw_pressure_i),
    .trim_i            (trim),
    .mid_full_i        (mid_full),
    .mid_push_o        (mid_push),
    .mid_word_o        (mid_in)
  );

  bsc_fifo #(
    .Width ($bits(bsc_mid_t)),
    .Depth (4)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .wdata_i (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .empty_o (mid_empty),
    .rdata_o (mid_out)
  );

  bsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trim_i      (trim),
    .mid_empty_i (mid_empty),
    .mid_word_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_full_i  (out_full),
    .out_push_o  (out_push),
    .out_word_o  (res_in)
  );

  bsc_fifo #(
    .Width ($bits(bsc_res_t)),
    .Depth (2)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (res_in),
    .full_o  (out_full),
    .pop_i   (pop),
    .empty_o (empty),
    .rdata_o (res_out)
  );

  assign temperature_centi_o = res_out.tc;
  assign pressure_q24_8_o    = res_out.pres;
  assign divisor_zero_o      = res_out.dz;

endmodule

// ===== verif/barometric_sensor_compensation_tb.sv =====
// testbench: barometric compensation block against a predictor, with random trims and stalls
`timescale 1ns / 100ps

module barometric_sensor_compensation_tb;
  import bsc_pkg::*;

  localparam int unsigned RawBits    = 20;
  localparam int unsigned Latency    = 98;
  localparam int unsigned CycleLimit = 600000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 push;
  logic                 full;
  logic [FieldBits-1:0] raw_temperature_i;
  logic [FieldBits-1:0] raw_pressure_i;
  logic                 pop;
  logic                 empty;
  logic signed [23:0]   temperature_centi_o;
  logic [31:0]          pressure_q24_8_o;
  logic                 divisor_zero_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i;
  logic [63:0]          cfg_data_i;

  logic [47:0] trim_t;
  logic [63:0] trim_pl;
  logic [63:0] trim_pm;
  logic [15:0] trim_ph;

  bsc_res_t    pending_readings[$];
  int unsigned errors;
  int unsigned cycles;
  int unsigned hold_req;
  int unsigned stall_cnt;

  barometric_sensor_compensation #(.RAW_BITS(RawBits)) u_dut (
    .clk_i, .rst_ni, .push, .full, .raw_temperature_i, .raw_pressure_i,
    .pop, .empty, .temperature_centi_o, .pressure_q24_8_o, .divisor_zero_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic bsc_res_t compensate(logic [19:0] rt_raw, logic [19:0] rp_raw);
    logic [19:0]         rmask;
    longint              rt, rp, t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    longint              va, vb, tfine, tc, v1, v2, big, x, p, q;
    logic [63:0]         m64;
    logic [127:0]        dmag, n, qq, pm, t1w, t2m, mq;
    logic signed [127:0] s, t1s, t2s;
    bit                  dneg, pneg;
    bsc_res_t            r;
    rmask = 20'(((1 << RawBits) - 1) << (20 - RawBits));
    rt = rt_raw & rmask;
    rp = rp_raw & rmask;
    t1 = trim_t[15:0];
    t2 = $signed(trim_t[31:16]);
    t3 = $signed(trim_t[47:32]);
    p1 = trim_pl[15:0];
    p2 = $signed(trim_pl[31:16]);
    p3 = $signed(trim_pl[47:32]);
    p4 = $signed(trim_pl[63:48]);
    p5 = $signed(trim_pm[15:0]);
    p6 = $signed(trim_pm[31:16]);
    p7 = $signed(trim_pm[47:32]);
    p8 = $signed(trim_pm[63:48]);
    p9 = $signed(trim_ph);

    va = ((rt / 8 - 2 * t1) * t2) / 2048;
    vb = (((rt / 16 - t1) * (rt / 16 - t1)) / 4096 * t3) / 16384;
    tfine = va + vb;
    tc = (tfine * 5 + 128) / 256;
    if (tc > 8388607) tc = 8388607;
    if (tc < -8388608) tc = -8388608;
    r.tc = tc[23:0];

    v1 = tfine - 128000;
    v2 = v1 * v1 * p6 + v1 * p5 * 131072 + p4 * 64'sd34359738368;
    big = 64'sh800000000000 + (v1 * v1 * p3) / 256 + v1 * p2 * 4096;
    m64 = big < 0 ? -big : big;
    dmag = ({64'b0, m64} * 128'(p1)) >> 33;
    dneg = big < 0;
    if (dmag == 0) begin
      r.pres = '0;
      r.dz   = 1'b1;
      return r;
    end

    x = (1048576 - rp) * 64'sd2147483648 - v2;
    m64 = x < 0 ? -x : x;
    n = {64'b0, m64} * 128'd3125;
    qq = n / dmag;
    pm = qq > (128'd1 << 60) ? (128'd1 << 60) : qq;
    pneg = (x < 0) != dneg;
    p = pneg ? -longint'(pm[63:0]) : longint'(pm[63:0]);

    q = p / 8192;
    m64 = q < 0 ? -q : q;
    mq = {64'b0, m64};
    t1w = (mq * mq * 128'(p9 < 0 ? -p9 : p9)) >> 25;
    t1s = p9 < 0 ? -$signed(t1w) : $signed(t1w);
    t2m = (pm * 128'(p8 < 0 ? -p8 : p8)) >> 19;
    t2s = ((p8 < 0) != pneg) ? -$signed(t2m) : $signed(t2m);

    s = p;
    s = s + t1s + t2s;
    s = s / 256;
    s = s + p7 * 16;
    if (s < 0) r.pres = '0;
    else if (s > $signed(128'hFFFFFFFF)) r.pres = '1;
    else r.pres = s[31:0];
    r.dz = 1'b0;
    return r;
  endfunction

  // one trim register per call; caller lowers valid after the last
  task automatic write_trim(bsc_cfg_e idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_TRIM_T:      trim_t  = data[47:0];
      CFG_TRIM_P_LOW:  trim_pl = data;
      CFG_TRIM_P_MID:  trim_pm = data;
      CFG_TRIM_P_HIGH: trim_ph = data[15:0];
    endcase
  endtask

  task automatic set_trims(logic [47:0] t, logic [63:0] pl, logic [63:0] pmid, logic [15:0] ph);
    write_trim(CFG_TRIM_T, {16'($urandom), t});
    write_trim(CFG_TRIM_P_LOW, pl);
    write_trim(CFG_TRIM_P_MID, pmid);
    write_trim(CFG_TRIM_P_HIGH, {48'($urandom), ph});
    cfg_valid_i <= 1'b0;
  endtask

  task automatic send_reading(logic [19:0] rt, logic [19:0] rp, bit no_gap = 0);
    int unsigned gap, pick;
    pick = $urandom_range(99);
    gap = no_gap ? 0 : (pick < 60) ? 0 : (pick < 95) ? $urandom_range(3, 1)
                                                       : $urandom_range(40, 10);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push              <= 1'b1;
    raw_temperature_i <= rt;
    raw_pressure_i    <= rp;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    pending_readings.push_back(compensate(rt, rp));
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  function automatic logic [19:0] rand_raw();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick == 0) return '0;
    if (pick == 1) return '1;
    return 20'($urandom);
  endfunction

  task automatic test_reset_trims();
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'h80000, 20'h7FFFF);
    wait_idle();
  endtask

  task automatic test_typical_trims();
    set_trims({16'(-1000), 16'(26435), 16'(27504)},
              {16'(2855), 16'(3024), 16'(-10685), 16'(36477)},
              {16'(-14600), 16'(15500), 16'(-7), 16'(140)}, 16'(6000));
    send_reading(20'd519888, 20'd415148);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading('0, '1);
    send_reading('1, '0);
    send_reading(20'h80000, 20'h80000);
    send_reading(20'd519888, 20'd1048575);
    wait_idle();
  endtask

  task automatic test_extreme_trims();
    set_trims('1, '1, '1, '1);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'h55555, 20'hAAAAA);
    wait_idle();
    set_trims({16'h8000, 16'h7FFF, 16'hFFFF}, {4{16'h7FFF}}, {4{16'h8000}}, 16'h8000);
    send_reading('0, '0);
    send_reading('1, '1);
    send_reading(20'hAAAAA, 20'h55555);
    wait_idle();
    set_trims({16'h7FFF, 16'h8000, 16'h0000}, {16'h8000, 16'h8000, 16'h8000, 16'h0001},
              {4{16'h7FFF}}, 16'h7FFF);
    send_reading('0, '1);
    send_reading('1, '0);
    send_reading(20'd400000, 20'd300000);
    wait_idle();
  endtask

  task automatic test_random_trims();
    for (int ph = 0; ph < 8; ph++) begin
      if (ph[0])
        set_trims(48'({$urandom, $urandom}), {$urandom, $urandom}, {$urandom, $urandom},
                  16'($urandom));
      else
        set_trims({16'($urandom_range(2000)) - 16'd1000, 16'(26000 + $urandom_range(1000)),
                   16'(27000 + $urandom_range(1000))},
                  {16'(2800 + $urandom_range(100)), 16'(3000 + $urandom_range(50)),
                   -16'(10600 + $urandom_range(100)), 16'(36000 + $urandom_range(1000))},
                  {-16'(14500 + $urandom_range(200)), 16'(15400 + $urandom_range(200)),
                   16'($urandom_range(14)) - 16'd7, 16'(130 + $urandom_range(20))},
                  16'(5900 + $urandom_range(200)));
      repeat (160) send_reading(rand_raw(), rand_raw());
      wait_idle();
    end
  endtask

  task automatic test_output_backpressure();
    set_trims({16'(-1000), 16'(26435), 16'(27504)},
              {16'(2855), 16'(3024), 16'(-10685), 16'(36477)},
              {16'(-14600), 16'(15500), 16'(-7), 16'(140)}, 16'(6000));
    hold_req = 600;
    repeat (250) send_reading(rand_raw(), rand_raw(), 1);
    wait_idle();
  endtask

  // receiver: random pop stalls, plus a long hold-off on request
  always @(posedge clk_i) begin
    int unsigned pick;
    if (hold_req > 0) begin
      pop      <= 1'b0;
      hold_req <= hold_req - 1;
    end else if (stall_cnt > 0) begin
      pop       <= 1'b0;
      stall_cnt <= stall_cnt - 1;
    end else begin
      pick = $urandom_range(99);
      pop <= 1'b1;
      if (pick >= 97) stall_cnt <= $urandom_range(60, 20);
      else if (pick >= 75) stall_cnt <= $urandom_range(3, 1);
    end
  end

  always @(posedge clk_i) begin
    bsc_res_t exp_word;
    if (rst_ni && pop && !empty) begin
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected word tc=%0d pres=%h dz=%b", $time,
                 temperature_centi_o, pressure_q24_8_o, divisor_zero_o);
        errors++;
      end else begin
        exp_word = pending_readings.pop_front();
        if (temperature_centi_o !== exp_word.tc) begin
          $display("%0t: temperature_centi expected %0d actual %0d", $time,
                   exp_word.tc, temperature_centi_o);
          errors++;
        end
        if (pressure_q24_8_o !== exp_word.pres) begin
          $display("%0t: pressure_q24_8 expected %h actual %h", $time,
                   exp_word.pres, pressure_q24_8_o);
          errors++;
        end
        if (divisor_zero_o !== exp_word.dz) begin
          $display("%0t: divisor_zero expected %b actual %b", $time,
                   exp_word.dz, divisor_zero_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    push              = 1'b0;
    pop               = 1'b0;
    raw_temperature_i = '0;
    raw_pressure_i    = '0;
    cfg_valid_i       = 1'b0;
    cfg_index_i       = CFG_TRIM_T;
    cfg_data_i        = '0;
    trim_t            = '0;
    trim_pl           = '0;
    trim_pm           = '0;
    trim_ph           = '0;
    errors            = 0;
    cycles            = 0;
    hold_req          = 0;
    stall_cnt         = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_trims();
    test_typical_trims();
    test_extreme_trims();
    test_random_trims();
    test_output_backpressure();
    if (pending_readings.size() == 0 && errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
